// File: hw/rtl/rhsl_pkg.sv
// Shared types, constants and arithmetic helpers for the ranged HSL/RGB color converter.
`default_nettype none

package rhsl_pkg;

    // Q0.16 constants, 65535 stands for 1.0
    localparam logic [15:0] Q_ONE        = 16'hFFFF;
    localparam logic [15:0] Q_HALF       = 16'd32767;
    localparam logic [15:0] Q_THIRD      = 16'd21845;
    localparam logic [15:0] Q_TWO_THIRDS = 16'd43690;

    // Register map of the configuration port
    localparam logic [1:0] REG_COLOR_MODE = 2'd0;
    localparam logic [1:0] REG_RGB_RANGES = 2'd1;
    localparam logic [1:0] REG_HSL_RANGES = 2'd2;

    // Pipeline layout
    localparam int QUOT_BITS          = 16;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int NORM_STAGES        = QUOT_BITS / DIV_BITS_PER_STAGE + 1;
    localparam int HSL_STAGES         = 7;
    localparam int NUM_STAGES         = NORM_STAGES + HSL_STAGES;

    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] bits;
    } div_t;

    typedef struct packed {
        logic        high;
        logic [15:0] t6;
    } ramp_t;

    // Four restoring-division steps; the quotient shifts in where the dividend leaves.
    function automatic div_t div_steps(input logic [16:0] rem, input logic [15:0] bits,
                                       input logic [7:0] rng);
        logic [16:0] den;
        logic [17:0] t;
        div_t        res;
        den      = {rng, 9'h000};
        res.rem  = rem;
        res.bits = bits;
        for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
            t        = {res.rem, res.bits[15]};
            res.bits = {res.bits[14:0], 1'b0};
            if (t >= 18'(den)) begin
                t           = t - 18'(den);
                res.bits[0] = 1'b1;
            end
            res.rem = t[16:0];
        end
        return res;
    endfunction

    // floor(y / 65535) for y below 2^34: fold the high half back onto the low half twice.
    function automatic logic [17:0] div_q_one(input logic [33:0] y);
        logic [17:0] hi;
        logic [18:0] s1;
        logic [2:0]  c;
        logic [16:0] s2;
        hi = y[33:16];
        s1 = 19'(hi) + 19'(y[15:0]);
        c  = s1[18:16];
        s2 = 17'(c) + 17'(s1[15:0]);
        return hi + 18'(c) + ((s2 >= 17'(Q_ONE)) ? 18'd1 : 18'd0);
    endfunction

    // Classify a wrapped hue into its segment and give six times its distance into a ramp.
    function automatic ramp_t hue_ramp(input logic [15:0] hh);
        logic [18:0] h6;
        logic [16:0] h2;
        logic [17:0] h3;
        logic [15:0] t;
        ramp_t       res;
        h6       = (19'(hh) << 2) + (19'(hh) << 1);
        h2       = 17'(hh) << 1;
        h3       = (18'(hh) << 1) + 18'(hh);
        t        = 16'h0000;
        res.high = 1'b0;
        if (h6 < 19'(Q_ONE)) begin
            t = hh;
        end else if (h2 < 17'(Q_ONE)) begin
            res.high = 1'b1;
        end else if (h3 < (18'(Q_ONE) << 1)) begin
            t = Q_TWO_THIRDS - hh;
        end
        res.t6 = (t << 2) + (t << 1);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ranged_hsl_rgb_color_convert.sv
// Top level of the ranged color converter: config registers, normalizers, HSL pipeline.
//
//  channel | signals                                          | direction | word
//  --------+--------------------------------------------------+-----------+-------------------
//  in      | in_valid/in_ready, four components, alpha_given  | to block  | one color
//  out     | out_valid/out_ready, red, green, blue, alpha     | from block| one RGBA, Q0.16
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data         | to block  | one register write
//
// One word enters per clock while in_ready is high; each word passes through the
// 5-stage range divider (4 quotient bits per division stage) and the 7-stage HSL pipeline.
// Reset clears all stage valids and loads the reset register values; cfg_ready stays high.
// A stall at the output fills empty stages first; in_ready drops only when every stage holds a word.
`default_nettype none

module ranged_hsl_rgb_color_convert
    import rhsl_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COMPONENT_BITS-1:0] first_component,
    input  logic [COMPONENT_BITS-1:0] second_component,
    input  logic [COMPONENT_BITS-1:0] third_component,
    input  logic [COMPONENT_BITS-1:0] alpha_component,
    input  logic                      alpha_given,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               red,
    output logic [15:0]               green,
    output logic [15:0]               blue,
    output logic [15:0]               alpha,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    logic        mode_reg, mode_next;
    logic [31:0] rgb_ranges_reg, rgb_ranges_next;
    logic [31:0] hsl_ranges_reg, hsl_ranges_next;
    logic [31:0] ranges;

    logic [NUM_STAGES-1:0] stage_en;
    logic [15:0]           norm_h, norm_s, norm_l, norm_a;

    always_comb
    begin
        mode_next       = mode_reg;
        rgb_ranges_next = rgb_ranges_reg;
        hsl_ranges_next = hsl_ranges_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_COLOR_MODE: mode_next       = cfg_data[0];
                REG_RGB_RANGES: rgb_ranges_next = cfg_data;
                REG_HSL_RANGES: hsl_ranges_next = cfg_data;
                default:        mode_next       = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= 1'b0;
            rgb_ranges_reg <= 32'hFFFF_FFFF;
            hsl_ranges_reg <= 32'hFFFF_FFFF;
        end else begin
            mode_reg       <= mode_next;
            rgb_ranges_reg <= rgb_ranges_next;
            hsl_ranges_reg <= hsl_ranges_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign ranges    = mode_reg ? hsl_ranges_reg : rgb_ranges_reg;

    rhsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stage_en  (stage_en)
    );

    rhsl_norm #(.COMPONENT_BITS(COMPONENT_BITS)) u_norm_h (
        .clk        (clk),
        .stage_en   (stage_en[NORM_STAGES-1:0]),
        .x          (first_component),
        .range_byte (ranges[7:0]),
        .set_full   (1'b0),
        .value      (norm_h)
    );

    rhsl_norm #(.COMPONENT_BITS(COMPONENT_BITS)) u_norm_s (
        .clk        (clk),
        .stage_en   (stage_en[NORM_STAGES-1:0]),
        .x          (second_component),
        .range_byte (ranges[15:8]),
        .set_full   (1'b0),
        .value      (norm_s)
    );

    rhsl_norm #(.COMPONENT_BITS(COMPONENT_BITS)) u_norm_l (
        .clk        (clk),
        .stage_en   (stage_en[NORM_STAGES-1:0]),
        .x          (third_component),
        .range_byte (ranges[23:16]),
        .set_full   (1'b0),
        .value      (norm_l)
    );

    // Missing alpha goes out as full opacity
    rhsl_norm #(.COMPONENT_BITS(COMPONENT_BITS)) u_norm_a (
        .clk        (clk),
        .stage_en   (stage_en[NORM_STAGES-1:0]),
        .x          (alpha_component),
        .range_byte (ranges[31:24]),
        .set_full   (~alpha_given),
        .value      (norm_a)
    );

    rhsl_hsl u_hsl (
        .clk      (clk),
        .stage_en (stage_en[NUM_STAGES-1:NORM_STAGES]),
        .mode     (mode_reg),
        .h        (norm_h),
        .s        (norm_s),
        .l        (norm_l),
        .a        (norm_a),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .alpha    (alpha)
    );

endmodule

`default_nettype wire

// File: hw/rtl/rhsl_ctrl.sv
// Valid tracking and per-stage load enables for the converter pipeline.
`default_nettype none

module rhsl_ctrl
    import rhsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NUM_STAGES-1:0] stage_en
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    // A stage loads when it is empty or the stage after it moves on.
    always_comb
    begin
        stage_en[NUM_STAGES-1] = ~valid_reg[NUM_STAGES-1] | out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = ~valid_reg[k] | stage_en[k+1];
        end
        valid_next = valid_reg;
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/rhsl_norm.sv
// Pipelined range normalization of one component: divide by its range, round, saturate.
`default_nettype none

module rhsl_norm
    import rhsl_pkg::*;
#(
    parameter int COMPONENT_BITS = 16
)
(
    input  logic                      clk,
    input  logic [NORM_STAGES-1:0]    stage_en,
    input  logic [COMPONENT_BITS-1:0] x,
    input  logic [7:0]                range_byte,
    input  logic                      set_full,
    output logic [15:0]               value
);

    localparam int XW = (COMPONENT_BITS > 16) ? COMPONENT_BITS : 16;

    logic [7:0]    rng_next;
    logic [XW-1:0] x_ext;
    logic [XW-1:0] limit;
    logic [33:0]   num;

    logic [16:0] rem_reg  [0:NORM_STAGES-2];
    logic [15:0] bits_reg [0:NORM_STAGES-2];
    logic [7:0]  rng_reg  [0:NORM_STAGES-2];
    logic        full_reg [0:NORM_STAGES-2];
    logic [15:0] value_reg;
    div_t        last_step;

    // Dividend is 2*x*65535 + 256*r over 512*r; x at or above 256*r saturates.
    always_comb
    begin
        rng_next = (range_byte == 8'h00) ? 8'hFF : range_byte;
        x_ext    = XW'(x);
        limit    = XW'({rng_next, 8'h00});
        num      = (34'(x_ext[15:0]) << 17) - (34'(x_ext[15:0]) << 1)
                   + 34'({rng_next, 8'h00});
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0]) begin
            rem_reg[0]  <= num[32:16];
            bits_reg[0] <= num[15:0];
            rng_reg[0]  <= rng_next;
            full_reg[0] <= set_full | (x_ext >= limit);
        end
    end

    for (genvar k = 1; k < NORM_STAGES - 1; k++) begin : g_div
        div_t step;
        always_comb
        begin
            step = div_steps(rem_reg[k-1], bits_reg[k-1], rng_reg[k-1]);
        end
        always_ff @(posedge clk)
        begin
            if (stage_en[k]) begin
                rem_reg[k]  <= step.rem;
                bits_reg[k] <= step.bits;
                rng_reg[k]  <= rng_reg[k-1];
                full_reg[k] <= full_reg[k-1];
            end
        end
    end

    always_comb
    begin
        last_step = div_steps(rem_reg[NORM_STAGES-2], bits_reg[NORM_STAGES-2],
                              rng_reg[NORM_STAGES-2]);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[NORM_STAGES-1]) begin
            value_reg <= full_reg[NORM_STAGES-2] ? Q_ONE : last_step.bits;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: hw/rtl/rhsl_hsl.sv
// Pipelined HSL to RGB conversion with RGB pass-through and the output register.
`default_nettype none

module rhsl_hsl
    import rhsl_pkg::*;
(
    input  logic                  clk,
    input  logic [HSL_STAGES-1:0] stage_en,
    input  logic                  mode,
    input  logic [15:0]           h,
    input  logic [15:0]           s,
    input  logic [15:0]           l,
    input  logic [15:0]           a,
    output logic [15:0]           red,
    output logic [15:0]           green,
    output logic [15:0]           blue,
    output logic [15:0]           alpha
);

    // Stage A: l * (1 + s) below half lightness, l * s above
    logic        pa_low_next;
    logic [16:0] pa_mb;
    logic [32:0] pa_prod_next;
    logic        pa_low_reg;
    logic [32:0] pa_prod_reg;
    logic [15:0] pa_h_reg, pa_s_reg, pa_l_reg, pa_a_reg;

    always_comb
    begin
        pa_low_next  = (17'(l) << 1) <= 17'(Q_ONE);
        pa_mb        = pa_low_next ? (17'(s) + 17'(Q_ONE)) : 17'(s);
        pa_prod_next = 33'(l) * 33'(pa_mb);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0]) begin
            pa_low_reg  <= pa_low_next;
            pa_prod_reg <= pa_prod_next;
            pa_h_reg    <= h;
            pa_s_reg    <= s;
            pa_l_reg    <= l;
            pa_a_reg    <= a;
        end
    end

    // Stage B: round the product back to Q0.16
    logic [17:0] pb_q_next;
    logic [15:0] pb_q_reg;
    logic        pb_low_reg;
    logic [15:0] pb_h_reg, pb_s_reg, pb_l_reg, pb_a_reg;

    always_comb
    begin
        pb_q_next = div_q_one(34'(pa_prod_reg) + 34'(Q_HALF));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1]) begin
            pb_q_reg   <= pb_q_next[15:0];
            pb_low_reg <= pa_low_reg;
            pb_h_reg   <= pa_h_reg;
            pb_s_reg   <= pa_s_reg;
            pb_l_reg   <= pa_l_reg;
            pb_a_reg   <= pa_a_reg;
        end
    end

    // Stage C: m2 and the three wrapped hues
    logic [17:0] pc_m2_raw;
    logic [15:0] pc_m2_next;
    logic [16:0] pc_hr_sum;
    logic [15:0] pc_hr_next, pc_hb_next;
    logic [15:0] pc_m2_reg, pc_hr_reg, pc_hb_reg;
    logic [15:0] pc_h_reg, pc_s_reg, pc_l_reg, pc_a_reg;

    always_comb
    begin
        pc_m2_raw  = pb_low_reg ? 18'(pb_q_reg)
                                : 18'(pb_l_reg) + 18'(pb_s_reg) - 18'(pb_q_reg);
        pc_m2_next = (pc_m2_raw > 18'(Q_ONE)) ? Q_ONE : pc_m2_raw[15:0];
        pc_hr_sum  = 17'(pb_h_reg) + 17'(Q_THIRD);
        pc_hr_next = (pc_hr_sum > 17'(Q_ONE)) ? 16'(pc_hr_sum - 17'(Q_ONE)) : pc_hr_sum[15:0];
        pc_hb_next = (pb_h_reg >= Q_THIRD) ? (pb_h_reg - Q_THIRD)
                                           : (pb_h_reg + (Q_ONE - Q_THIRD));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[2]) begin
            pc_m2_reg <= pc_m2_next;
            pc_hr_reg <= pc_hr_next;
            pc_hb_reg <= pc_hb_next;
            pc_h_reg  <= pb_h_reg;
            pc_s_reg  <= pb_s_reg;
            pc_l_reg  <= pb_l_reg;
            pc_a_reg  <= pb_a_reg;
        end
    end

    // Stage D: m1, ramp height d, hue segments
    logic [16:0] pd_two_l;
    logic [16:0] pd_m1_raw;
    logic [17:0] pd_two_m2;
    logic [15:0] pd_m1_next, pd_d_next;
    ramp_t       pd_rr_next, pd_rg_next, pd_rb_next;
    logic [15:0] pd_m1_reg, pd_m2_reg, pd_d_reg;
    ramp_t       pd_rr_reg, pd_rg_reg, pd_rb_reg;
    logic [15:0] pd_h_reg, pd_s_reg, pd_l_reg, pd_a_reg;

    always_comb
    begin
        pd_two_l  = 17'(pc_l_reg) << 1;
        pd_m1_raw = pd_two_l - 17'(pc_m2_reg);
        pd_two_m2 = 18'(pc_m2_reg) << 1;
        if (pd_two_l <= 17'(pc_m2_reg)) begin
            pd_m1_next = 16'h0000;
            pd_d_next  = pc_m2_reg;
        end else if (pd_m1_raw > 17'(Q_ONE)) begin
            pd_m1_next = Q_ONE;
            pd_d_next  = 16'h0000;
        end else begin
            pd_m1_next = pd_m1_raw[15:0];
            // d = m2 - m1 = 2*m2 - 2*l, floored at zero
            pd_d_next  = (pd_two_m2 > 18'(pd_two_l)) ? 16'(pd_two_m2 - 18'(pd_two_l)) : 16'h0000;
        end
        pd_rr_next = hue_ramp(pc_hr_reg);
        pd_rg_next = hue_ramp(pc_h_reg);
        pd_rb_next = hue_ramp(pc_hb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3]) begin
            pd_m1_reg <= pd_m1_next;
            pd_m2_reg <= pc_m2_reg;
            pd_d_reg  <= pd_d_next;
            pd_rr_reg <= pd_rr_next;
            pd_rg_reg <= pd_rg_next;
            pd_rb_reg <= pd_rb_next;
            pd_h_reg  <= pc_h_reg;
            pd_s_reg  <= pc_s_reg;
            pd_l_reg  <= pc_l_reg;
            pd_a_reg  <= pc_a_reg;
        end
    end

    // Stage E: ramp products d * 6t
    logic [31:0] pe_pr_next, pe_pg_next, pe_pb_next;
    logic [31:0] pe_pr_reg, pe_pg_reg, pe_pb_reg;
    logic        pe_hr_reg, pe_hg_reg, pe_hb_reg;
    logic [15:0] pe_m1_reg, pe_m2_reg;
    logic [15:0] pe_h_reg, pe_s_reg, pe_l_reg, pe_a_reg;

    always_comb
    begin
        pe_pr_next = 32'(pd_d_reg) * 32'(pd_rr_reg.t6);
        pe_pg_next = 32'(pd_d_reg) * 32'(pd_rg_reg.t6);
        pe_pb_next = 32'(pd_d_reg) * 32'(pd_rb_reg.t6);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[4]) begin
            pe_pr_reg <= pe_pr_next;
            pe_pg_reg <= pe_pg_next;
            pe_pb_reg <= pe_pb_next;
            pe_hr_reg <= pd_rr_reg.high;
            pe_hg_reg <= pd_rg_reg.high;
            pe_hb_reg <= pd_rb_reg.high;
            pe_m1_reg <= pd_m1_reg;
            pe_m2_reg <= pd_m2_reg;
            pe_h_reg  <= pd_h_reg;
            pe_s_reg  <= pd_s_reg;
            pe_l_reg  <= pd_l_reg;
            pe_a_reg  <= pd_a_reg;
        end
    end

    // Stage F: round ramp products back to Q0.16
    logic [17:0] pf_qr_next, pf_qg_next, pf_qb_next;
    logic [15:0] pf_qr_reg, pf_qg_reg, pf_qb_reg;
    logic        pf_hr_reg, pf_hg_reg, pf_hb_reg;
    logic [15:0] pf_m1_reg, pf_m2_reg;
    logic [15:0] pf_h_reg, pf_s_reg, pf_l_reg, pf_a_reg;

    always_comb
    begin
        pf_qr_next = div_q_one(34'(pe_pr_reg) + 34'(Q_HALF));
        pf_qg_next = div_q_one(34'(pe_pg_reg) + 34'(Q_HALF));
        pf_qb_next = div_q_one(34'(pe_pb_reg) + 34'(Q_HALF));
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5]) begin
            pf_qr_reg <= pf_qr_next[15:0];
            pf_qg_reg <= pf_qg_next[15:0];
            pf_qb_reg <= pf_qb_next[15:0];
            pf_hr_reg <= pe_hr_reg;
            pf_hg_reg <= pe_hg_reg;
            pf_hb_reg <= pe_hb_reg;
            pf_m1_reg <= pe_m1_reg;
            pf_m2_reg <= pe_m2_reg;
            pf_h_reg  <= pe_h_reg;
            pf_s_reg  <= pe_s_reg;
            pf_l_reg  <= pe_l_reg;
            pf_a_reg  <= pe_a_reg;
        end
    end

    // Stage G: pick ramp, plateau or base, then the mode and gray bypass
    logic [16:0] pg_sr, pg_sg, pg_sb;
    logic [15:0] pg_cr, pg_cg, pg_cb;
    logic [15:0] red_next, green_next, blue_next;
    logic [15:0] red_reg, green_reg, blue_reg, alpha_reg;

    always_comb
    begin
        pg_sr = 17'(pf_m1_reg) + 17'(pf_qr_reg);
        pg_sg = 17'(pf_m1_reg) + 17'(pf_qg_reg);
        pg_sb = 17'(pf_m1_reg) + 17'(pf_qb_reg);
        pg_cr = pf_hr_reg ? pf_m2_reg : ((pg_sr > 17'(Q_ONE)) ? Q_ONE : pg_sr[15:0]);
        pg_cg = pf_hg_reg ? pf_m2_reg : ((pg_sg > 17'(Q_ONE)) ? Q_ONE : pg_sg[15:0]);
        pg_cb = pf_hb_reg ? pf_m2_reg : ((pg_sb > 17'(Q_ONE)) ? Q_ONE : pg_sb[15:0]);
        if (!mode) begin
            red_next   = pf_h_reg;
            green_next = pf_s_reg;
            blue_next  = pf_l_reg;
        end else if (pf_s_reg == 16'h0000) begin
            red_next   = pf_l_reg;
            green_next = pf_l_reg;
            blue_next  = pf_l_reg;
        end else begin
            red_next   = pg_cr;
            green_next = pg_cg;
            blue_next  = pg_cb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= pf_a_reg;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = alpha_reg;

endmodule

`default_nettype wire
